// ===== sv/bst_pkg.sv =====
// Package for the block structure transpose.
// Holds operation and status codes, and the store sizes used by the transpose module.
package bst_pkg;
    localparam int MAX_CBLK   = 1024;
    localparam int MAX_EDGES  = 4096;
    localparam int MAX_BLOCKS = 8192;

    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_BUILD     = 2'd1,
        OP_READ_EDGE = 2'd2,
        OP_READ_ROW  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NO_BUILD = 2'd3
    } t_status;

    localparam int unsigned REG_CBLK_COUNT = 0;
endpackage

// ===== sv/bst_if.sv =====
// Item channel interfaces for the block structure transpose.
// Depends on bst_pkg for the operation and status codes.
interface bst_in_if import bst_pkg::*; ();
    logic        valid;
    logic        ready;
    t_op         operation;
    logic [9:0]  source_cblk;
    logic [9:0]  target_cblk;
    logic [12:0] block_number;
    logic        is_diagonal;
    logic [11:0] read_index;
    modport source(output valid, operation, source_cblk, target_cblk, block_number,
        is_diagonal, read_index, input ready);
    modport sink(input valid, operation, source_cblk, target_cblk, block_number,
        is_diagonal, read_index, output ready);
endinterface

interface bst_out_if import bst_pkg::*; ();
    logic        valid;
    logic        ready;
    t_status     status;
    logic [9:0]  row_cblk;
    logic [12:0] row_block;
    logic [12:0] row_start;
    logic [12:0] edge_count;
    modport source(output valid, status, row_cblk, row_block, row_start, edge_count,
        input ready);
    modport sink(input valid, status, row_cblk, row_block, row_start, edge_count,
        output ready);
endinterface

// ===== sv/block_structure_transpose.sv =====
// Block structure transpose: one sequencer over synchronous memories
// (edge list, per-target counts, scatter cursors, row starts, transposed entries).
// Uses bst_pkg and the channel interfaces in bst_if.
//
// A load steps through memory read, modify/write and result once accepted; a
// read through memory read, check and result. A build runs a pass over rows
// (per row, read of the count memory then write of start and cursor, then a
// step to leave the pass) then a pass over the loaded edges (edge read, cursor
// read and write per edge, then a step to leave), so its length grows with
// column_block_count and the edge total. After reset, and when the first load
// follows a build, a clearing pass walks all count entries, one per cycle,
// during which no item is taken. The result register holds one finished item;
// the next item is accepted in the cycle after it is taken.
module block_structure_transpose import bst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bst_in_if.sink      i_in,
    bst_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = $clog2(MAX_CBLK);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int NW = $clog2(MAX_EDGES + 1);
    localparam int CNW = $clog2(MAX_CBLK + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOAD_RD, S_LOAD_WR, S_ROW_RD, S_ROW_WR,
        S_EDGE_RD, S_EDGE_CUR, S_EDGE_WR, S_READ_RD, S_READ_WAIT, S_OUT
    } t_state;

    // memories
    logic [9:0]  m_esrc [MAX_EDGES];
    logic [9:0]  m_etgt [MAX_EDGES];
    logic [12:0] m_eblk [MAX_EDGES];
    logic [12:0] m_cnt  [MAX_CBLK];
    logic [12:0] m_cur  [MAX_CBLK];
    logic [12:0] m_start[MAX_CBLK];
    logic [9:0]  m_osrc [MAX_EDGES];
    logic [12:0] m_oblk [MAX_EDGES];

    t_state      r_state;
    logic [10:0] r_cfg;
    logic [NW-1:0] r_loaded;
    logic        r_built;
    logic [CNW-1:0] r_rows;
    logic [12:0] r_total;
    logic [CNW-1:0] r_ptr;      // clear / row walk index
    logic [NW-1:0]  r_eptr;     // edge walk index
    logic [12:0] r_sum;
    t_op         r_op;
    logic [9:0]  r_src, r_tgt;
    logic [12:0] r_blk;
    logic        r_diag;
    logic [11:0] r_idx;
    logic        r_clear_then_load;
    // memory read data
    logic [12:0] r_cnt_q, r_cur_q;
    logic [9:0]  r_esrc_q, r_etgt_q;
    logic [12:0] r_eblk_q, r_start_q, r_oblk_q;
    logic [9:0]  r_osrc_q;
    // result
    logic        r_ovalid;
    t_status     r_status;
    logic [9:0]  r_rc;
    logic [12:0] r_rb, r_rs;

    logic in_acc, ld_bad, cfg_wr;
    logic [CNW-1:0] rows_n;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = (paddr == 3'd0) ? {21'd0, r_cfg} : 32'd0;
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc = i_in.valid && i_in.ready;
    assign ld_bad = (32'(r_src) >= MAX_CBLK) || (32'(r_tgt) >= MAX_CBLK)
                  || (32'(r_blk) >= MAX_BLOCKS);
    assign rows_n = (32'(r_cfg) > MAX_CBLK) ? CNW'(MAX_CBLK) : CNW'(r_cfg);

    assign o_out.valid      = r_ovalid;
    assign o_out.status     = r_status;
    assign o_out.row_cblk   = r_rc;
    assign o_out.row_block  = r_rb;
    assign o_out.row_start  = r_rs;
    assign o_out.edge_count = 13'(r_loaded);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 11'd1;
        end else if (cfg_wr) begin
            r_cfg <= pwdata[10:0];
        end
    end

    // memory ports: reads registered, writes by state
    always_ff @(posedge i_clk) begin
        r_cnt_q  <= m_cnt[(r_state == S_LOAD_RD) ? r_tgt[CW-1:0] : r_ptr[CW-1:0]];
        r_cur_q  <= m_cur[r_etgt_q[CW-1:0]];
        r_esrc_q <= m_esrc[r_eptr[EW-1:0]];
        r_etgt_q <= m_etgt[r_eptr[EW-1:0]];
        r_eblk_q <= m_eblk[r_eptr[EW-1:0]];
        r_start_q <= m_start[r_idx[CW-1:0]];
        r_osrc_q <= m_osrc[r_idx[EW-1:0]];
        r_oblk_q <= m_oblk[r_idx[EW-1:0]];
        case (r_state)
            S_CLEAR:   m_cnt[r_ptr[CW-1:0]] <= 13'd0;
            S_LOAD_WR: if (!r_diag && !ld_bad && 32'(r_loaded) < MAX_EDGES) begin
                m_cnt[r_tgt[CW-1:0]] <= r_cnt_q + 13'd1;
                m_esrc[r_loaded[EW-1:0]] <= r_src;
                m_etgt[r_loaded[EW-1:0]] <= r_tgt;
                m_eblk[r_loaded[EW-1:0]] <= r_blk;
            end
            S_ROW_WR: begin
                m_start[r_ptr[CW-1:0]] <= r_sum;
                m_cur[r_ptr[CW-1:0]]   <= r_sum;
            end
            S_EDGE_WR: if (32'(r_etgt_q) < 32'(r_rows)) begin
                m_cur[r_etgt_q[CW-1:0]] <= r_cur_q + 13'd1;
                if (32'(r_cur_q) < MAX_EDGES) begin
                    m_osrc[r_cur_q[EW-1:0]] <= r_esrc_q;
                    m_oblk[r_cur_q[EW-1:0]] <= r_eblk_q;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ptr    <= '0;
            r_loaded <= '0;
            r_built  <= 1'b0;
            r_ovalid <= 1'b0;
            r_rows   <= '0;
            r_total  <= '0;
            r_clear_then_load <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (32'(r_ptr) == MAX_CBLK - 1) begin
                        r_ptr <= '0;
                        r_state <= r_clear_then_load ? S_LOAD_RD : S_IDLE;
                        r_clear_then_load <= 1'b0;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_IDLE: if (in_acc) begin
                    r_op  <= i_in.operation;
                    r_src <= i_in.source_cblk;
                    r_tgt <= i_in.target_cblk;
                    r_blk <= i_in.block_number;
                    r_diag <= i_in.is_diagonal;
                    r_idx <= i_in.read_index;
                    r_status <= ST_OK;
                    r_rc <= '0;
                    r_rb <= '0;
                    r_rs <= '0;
                    unique case (i_in.operation)
                        OP_LOAD: begin
                            if (r_built) begin
                                r_built <= 1'b0;
                                r_loaded <= '0;
                                r_ptr <= '0;
                                r_clear_then_load <= 1'b1;
                                r_state <= S_CLEAR;
                            end else begin
                                r_state <= S_LOAD_RD;
                            end
                        end
                        OP_BUILD: begin
                            r_ptr <= '0;
                            r_sum <= '0;
                            r_rows <= rows_n;
                            r_state <= S_ROW_RD;
                        end
                        default: r_state <= S_READ_RD;
                    endcase
                end
                S_LOAD_RD: r_state <= S_LOAD_WR;
                S_LOAD_WR: begin
                    if (!r_diag) begin
                        if (ld_bad) r_status <= ST_RANGE;
                        else if (32'(r_loaded) >= MAX_EDGES) r_status <= ST_FULL;
                        else r_loaded <= r_loaded + 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_ROW_RD: begin
                    if (r_ptr == r_rows) begin
                        r_total <= r_sum;
                        r_eptr <= '0;
                        r_state <= S_EDGE_RD;
                    end else begin
                        r_state <= S_ROW_WR;
                    end
                end
                S_ROW_WR: begin
                    r_sum <= r_sum + r_cnt_q;
                    r_ptr <= r_ptr + 1'b1;
                    r_state <= S_ROW_RD;
                end
                S_EDGE_RD: begin
                    if (r_eptr == r_loaded) begin
                        r_built <= 1'b1;
                        r_rs <= r_total;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_EDGE_CUR;
                    end
                end
                S_EDGE_CUR: r_state <= S_EDGE_WR;
                S_EDGE_WR: begin
                    r_eptr <= r_eptr + 1'b1;
                    r_state <= S_EDGE_RD;
                end
                S_READ_RD: r_state <= S_READ_WAIT;
                S_READ_WAIT: begin
                    if (!r_built) begin
                        r_status <= ST_NO_BUILD;
                    end else if (r_op == OP_READ_EDGE) begin
                        if (32'(r_idx) >= 32'(r_total) || 32'(r_idx) >= MAX_EDGES)
                            r_status <= ST_RANGE;
                        else begin
                            r_rc <= r_osrc_q;
                            r_rb <= r_oblk_q;
                        end
                    end else begin
                        if (32'(r_idx) < 32'(r_rows)) r_rs <= r_start_q;
                        else if (32'(r_idx) == 32'(r_rows)) r_rs <= r_total;
                        else r_status <= ST_RANGE;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("item accepted while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_ovalid || $past(r_ovalid))
        else $error("result produced during clear");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_loaded) <= MAX_EDGES)
        else $error("edge count overflow");
endmodule
